### rtl/epoch_seconds_calendar_converter_defines.svh
// assertion macros shared by the converter rtl
`ifndef EPOCH_SECONDS_CALENDAR_CONVERTER_DEFINES_SVH
`define EPOCH_SECONDS_CALENDAR_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ESCC_ASSERT_IMPL(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("escc: same-cycle check failed");
// next-cycle implication
`define ESCC_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("escc: next-cycle check failed");
`else
`define ESCC_ASSERT_IMPL(name, clk, rst_n, cond, prop)
`define ESCC_ASSERT_NEXT(name, clk, rst_n, cond, prop)
`endif

`endif

### rtl/escc_pkg.sv
`default_nettype none

package escc_pkg;

    // operation select
    typedef enum logic {
        OP_TO_CALENDAR = 1'b0,
        OP_TO_COUNTER  = 1'b1
    } opcode_t;

    localparam int NUM_STAGES = 10;

    // calendar constants
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
    localparam logic [21:0] EPOCH_JDN       = 22'd2440588;
    localparam logic [21:0] JDN_SHIFT       = 22'd32044;
    localparam logic [23:0] DAYS_400Y       = 24'd146097;
    localparam logic [17:0] DAYS_4Y         = 18'd1461;
    localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
    localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;
    localparam logic [13:0] YEAR_BASE       = 14'd4800;
    localparam logic [6:0]  YEARS_PER_CENT  = 7'd100;
    localparam logic [31:0] JDN_BIAS        = 32'd2472633;  // 32045 plus the epoch day
    localparam logic [3:0]  MONTH_WRAP      = 4'd10;
    localparam logic [10:0] MONTH_SCALE     = 11'd5;
    localparam logic [10:0] MONTH_ROUND     = 11'd2;

    // four-century cycles reachable from a 32-bit counter: 67 through 69
    localparam logic [6:0]  CYCLE_BASE      = 7'd67;
    localparam logic [23:0] CYCLE_T1        = 24'd9934596;   // 68 times DAYS_400Y
    localparam logic [23:0] CYCLE_T2        = 24'd10080693;  // 69 times DAYS_400Y

    // reciprocals for division by constants
    localparam logic [15:0] DAY_RECIP       = 16'd49710;     // 2^25 / 675
    localparam logic [12:0] HOUR_RECIP      = 13'd4661;      // 2^20 / 225, exact here
    localparam logic [12:0] MIN_RECIP       = 13'd4370;      // 2^16 / 15, exact here
    localparam logic [22:0] WDAY_RECIP      = 23'd4793491;   // 2^25 / 7, exact here
    localparam logic [10:0] CENT_RECIP      = 11'd1311;      // 2^15 / 25, exact here
    localparam logic [7:0]  DAYS4Y_RECIP    = 8'd179;        // 2^18 / 1461, one fixup
    localparam logic [10:0] MONTH_RECIP     = 11'd1714;      // 2^18 / 153, exact here

    // days before the start of a march-based month: (153 m + 2) / 5
    function automatic logic [8:0] month_day_offset(input logic [3:0] m);
        logic [8:0] ofs;
        case (m)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            4'd12:   ofs = 9'd367;
            4'd13:   ofs = 9'd398;
            4'd14:   ofs = 9'd428;
            default: ofs = 9'd459;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

### rtl/epoch_seconds_calendar_converter.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into a Gregorian
// date-time with weekday (opcode 0, 0 = Monday), or calendar fields back into the
// counter modulo 2^32 (opcode 1); fields an operation does not produce read zero.
// The datapath is a ten-stage pipeline that takes one beat per cycle unless the
// output stalls it. The depth is set by the chain of constant divisions of the
// calendar direction (day, hour, four-century cycle, four-year cycle, month), each
// done as a reciprocal multiply with at most one fixup, but for the four-century
// cycle, found by threshold compares. A stage holds its beat while the output is
// stalled and all later stages are full; in_ready drops only once all ten are full.
`default_nettype none
`include "epoch_seconds_calendar_converter_defines.svh"

module epoch_seconds_calendar_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [31:0] seconds_count,
    input  wire logic [11:0] year_in,
    input  wire logic [3:0]  month_in,
    input  wire logic [4:0]  day_in,
    input  wire logic [4:0]  hour_in,
    input  wire logic [5:0]  minute_in,
    input  wire logic [5:0]  second_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      seconds_out,
    output logic [11:0]      year_out,
    output logic [3:0]       month_out,
    output logic [4:0]       day_out,
    output logic [4:0]       hour_out,
    output logic [5:0]       minute_out,
    output logic [5:0]       second_out,
    output logic [2:0]       weekday_out
);

    // pipeline control
    logic [escc_pkg::NUM_STAGES-1:0] vld_reg;
    logic [escc_pkg::NUM_STAGES-1:0] adv;

    // stage 1
    escc_pkg::opcode_t s1_op_reg;
    logic [31:0] s1_cnt_reg;
    logic [40:0] s1_dayp_reg, s1_dayp_next;
    logic [13:0] s1_y_reg, s1_y_next;
    logic [8:0]  s1_t1_reg, s1_t1_next;
    logic [21:0] s1_p100_reg, s1_p100_next;
    logic [19:0] s1_p400_reg, s1_p400_next;
    logic [16:0] s1_tod_reg, s1_tod_next;
    logic        rev_shift;
    logic [3:0]  rev_mon;

    // stage 2
    escc_pkg::opcode_t s2_op_reg;
    logic [15:0] s2_q0_reg;
    logic [17:0] s2_r0_reg, s2_r0_next;
    logic [31:0] s2_jdn32_reg, s2_jdn32_next;
    logic [16:0] s2_tod_reg;
    logic [31:0] s2_diff;
    logic [6:0]  s2_q100;
    logic [4:0]  s2_q400;

    // stage 3
    escc_pkg::opcode_t s3_op_reg;
    logic [21:0] s3_jdn_reg, s3_jdn_next;
    logic [16:0] s3_sod_reg, s3_sod_next;
    logic [31:0] s3_tmul_reg, s3_tmul_next;
    logic [16:0] s3_tod_reg;
    logic [15:0] s3_days;

    // stage 4
    escc_pkg::opcode_t s4_op_reg;
    logic [24:0] s4_hourp_reg, s4_hourp_next;
    logic [43:0] s4_wkp_reg, s4_wkp_next;
    logic [21:0] s4_a_reg, s4_a_next;
    logic [6:0]  s4_b_reg, s4_b_next;
    logic [21:0] s4_jdn_reg;
    logic [16:0] s4_sod_reg;
    logic [31:0] s4_secs_reg, s4_secs_next;
    logic [23:0] s4_v;

    // stage 5
    escc_pkg::opcode_t s5_op_reg;
    logic [4:0]  s5_hour_reg, s5_hour_next;
    logic [11:0] s5_remh_reg, s5_remh_next;
    logic [2:0]  s5_wday_reg, s5_wday_next;
    logic [15:0] s5_c_reg, s5_c_next;
    logic [6:0]  s5_b_reg;
    logic [31:0] s5_secs_reg;
    logic [18:0] s5_q7;
    logic [23:0] s5_cyc;

    // stage 6
    escc_pkg::opcode_t s6_op_reg;
    logic [21:0] s6_minp_reg, s6_minp_next;
    logic [11:0] s6_remh_reg;
    logic [17:0] s6_dx_reg, s6_dx_next;
    logic [24:0] s6_dp_reg, s6_dp_next;
    logic [15:0] s6_c_reg;
    logic [4:0]  s6_hour_reg;
    logic [2:0]  s6_wday_reg;
    logic [6:0]  s6_b_reg;
    logic [31:0] s6_secs_reg;

    // stage 7
    escc_pkg::opcode_t s7_op_reg;
    logic [5:0]  s7_min_reg, s7_min_next;
    logic [5:0]  s7_sec_reg, s7_sec_next;
    logic [6:0]  s7_d_reg, s7_d_next;
    logic [15:0] s7_c_reg;
    logic [4:0]  s7_hour_reg;
    logic [2:0]  s7_wday_reg;
    logic [6:0]  s7_b_reg;
    logic [31:0] s7_secs_reg;
    logic [6:0]  s7_d0;
    logic [17:0] s7_rem;

    // stage 8
    escc_pkg::opcode_t s8_op_reg;
    logic [8:0]  s8_e_reg, s8_e_next;
    logic [6:0]  s8_d_reg;
    logic [5:0]  s8_min_reg;
    logic [5:0]  s8_sec_reg;
    logic [4:0]  s8_hour_reg;
    logic [2:0]  s8_wday_reg;
    logic [6:0]  s8_b_reg;
    logic [31:0] s8_secs_reg;

    // stage 9
    escc_pkg::opcode_t s9_op_reg;
    logic [21:0] s9_mp_reg, s9_mp_next;
    logic [8:0]  s9_e_reg;
    logic [6:0]  s9_d_reg;
    logic [5:0]  s9_min_reg;
    logic [5:0]  s9_sec_reg;
    logic [4:0]  s9_hour_reg;
    logic [2:0]  s9_wday_reg;
    logic [6:0]  s9_b_reg;
    logic [31:0] s9_secs_reg;
    logic [10:0] s9_x;

    // stage 10, output registers
    logic [31:0] seconds_out_reg, seconds_out_next;
    logic [11:0] year_out_reg, year_out_next;
    logic [3:0]  month_out_reg, month_out_next;
    logic [4:0]  day_out_reg, day_out_next;
    logic [4:0]  hour_out_reg, hour_out_next;
    logic [5:0]  minute_out_reg, minute_out_next;
    logic [5:0]  second_out_reg, second_out_next;
    logic [2:0]  weekday_out_reg, weekday_out_next;
    logic [3:0]  s10_m;
    logic        s10_wrap;

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[escc_pkg::NUM_STAGES-1] = !vld_reg[escc_pkg::NUM_STAGES-1] || out_ready;
        for (int k = escc_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[escc_pkg::NUM_STAGES-1];

    // valid bits travel with the beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < escc_pkg::NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: day reciprocal product, calendar-side terms
    always_comb
    begin
        s1_dayp_next = 41'(seconds_count[31:7]) * 41'(escc_pkg::DAY_RECIP);
        rev_shift    = (month_in <= 4'd2);
        s1_y_next    = 14'(year_in) + escc_pkg::YEAR_BASE - 14'(rev_shift);
        rev_mon      = rev_shift ? (month_in + 4'd9) : (month_in - 4'd3);
        s1_t1_next   = 9'(day_in) + escc_pkg::month_day_offset(rev_mon);
        s1_p100_next = 22'(s1_y_next[13:2]) * 22'(escc_pkg::CENT_RECIP);
        s1_p400_next = 20'(s1_y_next[13:4]) * 20'(escc_pkg::CENT_RECIP);
        s1_tod_next  = 17'(hour_in) * 17'(escc_pkg::SECS_PER_HOUR)
                     + 17'(minute_in) * 17'(escc_pkg::SECS_PER_MIN)
                     + 17'(second_in);
    end

    // stage 2: day remainder estimate, day number of the calendar side
    always_comb
    begin
        s2_diff       = s1_cnt_reg
                      - 32'(s1_dayp_reg[40:25]) * 32'(escc_pkg::SECS_PER_DAY);
        s2_r0_next    = s2_diff[17:0];
        s2_q100       = s1_p100_reg[21:15];
        s2_q400       = s1_p400_reg[19:15];
        s2_jdn32_next = 32'(s1_y_reg) * 32'(escc_pkg::DAYS_PER_YEAR)
                      + 32'(s1_y_reg[13:2]) + 32'(s2_q400) - 32'(s2_q100)
                      + 32'(s1_t1_reg) - escc_pkg::JDN_BIAS;
    end

    // stage 3: day fixup, seconds of the calendar days
    always_comb
    begin
        if (s2_r0_reg >= 18'(escc_pkg::SECS_PER_DAY))
        begin
            s3_days     = s2_q0_reg + 16'd1;
            s3_sod_next = 17'(s2_r0_reg - 18'(escc_pkg::SECS_PER_DAY));
        end
        else
        begin
            s3_days     = s2_q0_reg;
            s3_sod_next = s2_r0_reg[16:0];
        end
        s3_jdn_next  = 22'(s3_days) + escc_pkg::EPOCH_JDN;
        s3_tmul_next = s2_jdn32_reg * 32'(escc_pkg::SECS_PER_DAY);
    end

    // stage 4: hour and weekday products, four-century cycle
    always_comb
    begin
        s4_hourp_next = 25'(s3_sod_reg[16:4]) * 25'(escc_pkg::HOUR_RECIP);
        s4_wkp_next   = 44'(s3_jdn_reg) * 44'(escc_pkg::WDAY_RECIP);
        s4_a_next     = s3_jdn_reg + escc_pkg::JDN_SHIFT;
        s4_v          = {s4_a_next, 2'b11};
        s4_b_next     = escc_pkg::CYCLE_BASE + 7'(s4_v >= escc_pkg::CYCLE_T1)
                      + 7'(s4_v >= escc_pkg::CYCLE_T2);
        s4_secs_next  = s3_tmul_reg + 32'(s3_tod_reg);
    end

    // stage 5: hour, weekday, day within the cycle
    always_comb
    begin
        s5_hour_next = s4_hourp_reg[24:20];
        s5_remh_next = 12'(s4_sod_reg
                     - 17'(s5_hour_next) * 17'(escc_pkg::SECS_PER_HOUR));
        s5_q7        = s4_wkp_reg[43:25];
        s5_wday_next = 3'(s4_jdn_reg - 22'(s5_q7) * 22'(escc_pkg::DAYS_PER_WEEK));
        s5_cyc       = 24'(s4_b_reg) * escc_pkg::DAYS_400Y;
        s5_c_next    = 16'(s4_a_reg - 22'(s5_cyc >> 2));
    end

    // stage 6: minute product, four-year cycle estimate
    always_comb
    begin
        s6_minp_next = 22'(s5_remh_reg[11:2]) * 22'(escc_pkg::MIN_RECIP);
        s6_dx_next   = {s5_c_reg, 2'b11};
        s6_dp_next   = 25'(s6_dx_next) * 25'(escc_pkg::DAYS4Y_RECIP);
    end

    // stage 7: minute, second, four-year cycle fixup
    always_comb
    begin
        s7_min_next = s6_minp_reg[21:16];
        s7_sec_next = 6'(s6_remh_reg - 12'(s7_min_next) * 12'(escc_pkg::SECS_PER_MIN));
        s7_d0       = s6_dp_reg[24:18];
        s7_rem      = s6_dx_reg - 18'(s7_d0) * escc_pkg::DAYS_4Y;
        s7_d_next   = s7_d0 + 7'(s7_rem >= escc_pkg::DAYS_4Y);
    end

    // stage 8: day of the march-based year
    always_comb
    begin
        s8_e_next = 9'(s7_c_reg - 16'((18'(s7_d_reg) * escc_pkg::DAYS_4Y) >> 2));
    end

    // stage 9: month product
    always_comb
    begin
        s9_x       = 11'(s8_e_reg) * escc_pkg::MONTH_SCALE + escc_pkg::MONTH_ROUND;
        s9_mp_next = 22'(s9_x) * 22'(escc_pkg::MONTH_RECIP);
    end

    // stage 10: day, month, year and the result select
    always_comb
    begin
        s10_m    = s9_mp_reg[21:18];
        s10_wrap = (s10_m >= escc_pkg::MONTH_WRAP);
        if (s9_op_reg == escc_pkg::OP_TO_COUNTER)
        begin
            seconds_out_next = s9_secs_reg;
            year_out_next    = '0;
            month_out_next   = '0;
            day_out_next     = '0;
            hour_out_next    = '0;
            minute_out_next  = '0;
            second_out_next  = '0;
            weekday_out_next = '0;
        end
        else
        begin
            seconds_out_next = '0;
            year_out_next    = 12'(14'(s9_b_reg) * 14'(escc_pkg::YEARS_PER_CENT)
                             + 14'(s9_d_reg) + 14'(s10_wrap) - escc_pkg::YEAR_BASE);
            // march-based month back to january-based
            month_out_next   = s10_wrap ? (s10_m - 4'd9) : (s10_m + 4'd3);
            day_out_next     = 5'(s9_e_reg - escc_pkg::month_day_offset(s10_m) + 9'd1);
            hour_out_next    = s9_hour_reg;
            minute_out_next  = s9_min_reg;
            second_out_next  = s9_sec_reg;
            weekday_out_next = s9_wday_reg;
        end
    end

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_op_reg   <= escc_pkg::opcode_t'(opcode);
            s1_cnt_reg  <= seconds_count;
            s1_dayp_reg <= s1_dayp_next;
            s1_y_reg    <= s1_y_next;
            s1_t1_reg   <= s1_t1_next;
            s1_p100_reg <= s1_p100_next;
            s1_p400_reg <= s1_p400_next;
            s1_tod_reg  <= s1_tod_next;
        end
        if (adv[1])
        begin
            s2_op_reg    <= s1_op_reg;
            s2_q0_reg    <= s1_dayp_reg[40:25];
            s2_r0_reg    <= s2_r0_next;
            s2_jdn32_reg <= s2_jdn32_next;
            s2_tod_reg   <= s1_tod_reg;
        end
        if (adv[2])
        begin
            s3_op_reg   <= s2_op_reg;
            s3_jdn_reg  <= s3_jdn_next;
            s3_sod_reg  <= s3_sod_next;
            s3_tmul_reg <= s3_tmul_next;
            s3_tod_reg  <= s2_tod_reg;
        end
        if (adv[3])
        begin
            s4_op_reg    <= s3_op_reg;
            s4_hourp_reg <= s4_hourp_next;
            s4_wkp_reg   <= s4_wkp_next;
            s4_a_reg     <= s4_a_next;
            s4_b_reg     <= s4_b_next;
            s4_jdn_reg   <= s3_jdn_reg;
            s4_sod_reg   <= s3_sod_reg;
            s4_secs_reg  <= s4_secs_next;
        end
        if (adv[4])
        begin
            s5_op_reg   <= s4_op_reg;
            s5_hour_reg <= s5_hour_next;
            s5_remh_reg <= s5_remh_next;
            s5_wday_reg <= s5_wday_next;
            s5_c_reg    <= s5_c_next;
            s5_b_reg    <= s4_b_reg;
            s5_secs_reg <= s4_secs_reg;
        end
        if (adv[5])
        begin
            s6_op_reg   <= s5_op_reg;
            s6_minp_reg <= s6_minp_next;
            s6_remh_reg <= s5_remh_reg;
            s6_dx_reg   <= s6_dx_next;
            s6_dp_reg   <= s6_dp_next;
            s6_c_reg    <= s5_c_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_wday_reg <= s5_wday_reg;
            s6_b_reg    <= s5_b_reg;
            s6_secs_reg <= s5_secs_reg;
        end
        if (adv[6])
        begin
            s7_op_reg   <= s6_op_reg;
            s7_min_reg  <= s7_min_next;
            s7_sec_reg  <= s7_sec_next;
            s7_d_reg    <= s7_d_next;
            s7_c_reg    <= s6_c_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_wday_reg <= s6_wday_reg;
            s7_b_reg    <= s6_b_reg;
            s7_secs_reg <= s6_secs_reg;
        end
        if (adv[7])
        begin
            s8_op_reg   <= s7_op_reg;
            s8_e_reg    <= s8_e_next;
            s8_d_reg    <= s7_d_reg;
            s8_min_reg  <= s7_min_reg;
            s8_sec_reg  <= s7_sec_reg;
            s8_hour_reg <= s7_hour_reg;
            s8_wday_reg <= s7_wday_reg;
            s8_b_reg    <= s7_b_reg;
            s8_secs_reg <= s7_secs_reg;
        end
        if (adv[8])
        begin
            s9_op_reg   <= s8_op_reg;
            s9_mp_reg   <= s9_mp_next;
            s9_e_reg    <= s8_e_reg;
            s9_d_reg    <= s8_d_reg;
            s9_min_reg  <= s8_min_reg;
            s9_sec_reg  <= s8_sec_reg;
            s9_hour_reg <= s8_hour_reg;
            s9_wday_reg <= s8_wday_reg;
            s9_b_reg    <= s8_b_reg;
            s9_secs_reg <= s8_secs_reg;
        end
        if (adv[9])
        begin
            seconds_out_reg <= seconds_out_next;
            year_out_reg    <= year_out_next;
            month_out_reg   <= month_out_next;
            day_out_reg     <= day_out_next;
            hour_out_reg    <= hour_out_next;
            minute_out_reg  <= minute_out_next;
            second_out_reg  <= second_out_next;
            weekday_out_reg <= weekday_out_next;
        end
    end

    // result beat
    assign seconds_out = seconds_out_reg;
    assign year_out    = year_out_reg;
    assign month_out   = month_out_reg;
    assign day_out     = day_out_reg;
    assign hour_out    = hour_out_reg;
    assign minute_out  = minute_out_reg;
    assign second_out  = second_out_reg;
    assign weekday_out = weekday_out_reg;

    // checks
    `ESCC_ASSERT_NEXT(a_accept_fills_stage1, clk, rst_n, in_valid && in_ready, vld_reg[0])
    `ESCC_ASSERT_IMPL(a_blocked_only_when_full, clk, rst_n, !in_ready, &vld_reg)
    `ESCC_ASSERT_IMPL(a_day_fixup_in_range, clk, rst_n, vld_reg[2], s3_sod_reg < escc_pkg::SECS_PER_DAY)
    `ESCC_ASSERT_IMPL(a_calendar_result_sane, clk, rst_n, out_valid && month_out != 4'd0, month_out <= 4'd12 && day_out != 5'd0 && hour_out < 5'd24 && minute_out < 6'd60 && second_out < 6'd60 && weekday_out < 3'd7 && seconds_out == 32'd0)

endmodule

`default_nettype wire

### test/tb_epoch_seconds_calendar_converter.sv
`timescale 1ns / 1ps

module tb_epoch_seconds_calendar_converter;

    // watchdog limit in cycles with no beat on either side
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_ITEMS  = 450;
    localparam logic [63:0] LOW32_MASK    = 64'hFFFF_FFFF;
    localparam logic [63:0] DAY_SECS      = 64'd86400;
    localparam logic [63:0] UNIX_DAY0_JDN = 64'd2440588;

    // one request beat and one result beat
    typedef struct packed {
        escc_pkg::opcode_t op;
        logic [31:0]       secs;
        logic [11:0]       year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } conv_req_t;

    typedef struct packed {
        logic [31:0] secs;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } conv_res_t;

    // directed row: fixed result where it is obvious, else predicted
    typedef struct {
        conv_req_t req;
        bit        fixed;
        conv_res_t res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [31:0] seconds_count;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] seconds_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;

    conv_res_t   expected_dates[$];
    stim_row_t   date_table[$];
    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned cycle_count;
    int unsigned stall_left;
    conv_res_t   head;

    epoch_seconds_calendar_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .seconds_count (seconds_count),
        .year_in       (year_in),
        .month_in      (month_in),
        .day_in        (day_in),
        .hour_in       (hour_in),
        .minute_in     (minute_in),
        .second_in     (second_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .seconds_out   (seconds_out),
        .year_out      (year_out),
        .month_out     (month_out),
        .day_out       (day_out),
        .hour_out      (hour_out),
        .minute_out    (minute_out),
        .second_out    (second_out),
        .weekday_out   (weekday_out)
    );

    always #5 clk = ~clk;

    // counter to calendar, or calendar to counter mod 2^32
    function automatic conv_res_t convert_date(input conv_req_t r);
        conv_res_t   res;
        logic [63:0] cnt, jdn, a, b, c, d, e, m;
        logic [63:0] yr, mo, dy, hr, mn, sc, shift, y, t;
        res = '0;
        if (r.op == escc_pkg::OP_TO_CALENDAR)
        begin
            cnt = {32'd0, r.secs};
            jdn = cnt / DAY_SECS + UNIX_DAY0_JDN;
            a   = jdn + 64'd32044;
            b   = (64'd4 * a + 64'd3) / 64'd146097;
            c   = a - (64'd146097 * b) / 64'd4;
            d   = (64'd4 * c + 64'd3) / 64'd1461;
            e   = c - (64'd1461 * d) / 64'd4;
            m   = (64'd5 * e + 64'd2) / 64'd153;
            res.second = 6'(cnt % 64'd60);
            res.minute = 6'((cnt / 64'd60) % 64'd60);
            res.hour   = 5'((cnt / 64'd3600) % 64'd24);
            res.wday   = 3'(jdn % 64'd7);
            res.day    = 5'(e - (64'd153 * m + 64'd2) / 64'd5 + 64'd1);
            res.month  = 4'(m + 64'd3 - 64'd12 * (m / 64'd10));
            res.year   = 12'(64'd100 * b + d - 64'd4800 + m / 64'd10);
        end
        else
        begin
            yr    = {52'd0, r.year};
            mo    = {60'd0, r.month};
            dy    = {59'd0, r.day};
            hr    = {59'd0, r.hour};
            mn    = {58'd0, r.minute};
            sc    = {58'd0, r.second};
            // january and february count as months of the previous year
            shift = (mo <= 64'd2) ? 64'd1 : 64'd0;
            y     = yr + 64'd4800 - shift;
            m     = mo + 64'd12 * shift - 64'd3;
            jdn   = dy + (64'd153 * m + 64'd2) / 64'd5 + 64'd365 * y + y / 64'd4 + y / 64'd400;
            jdn   = (jdn - y / 64'd100 - 64'd32045 - UNIX_DAY0_JDN) & LOW32_MASK;
            t     = (jdn * DAY_SECS) & LOW32_MASK;
            t     = (t + hr * 64'd3600 + mn * 64'd60 + sc) & LOW32_MASK;
            res.secs = t[31:0];
        end
        return res;
    endfunction

    function automatic conv_req_t count_req(input logic [31:0] s);
        conv_req_t r;
        r      = '0;
        r.op   = escc_pkg::OP_TO_CALENDAR;
        r.secs = s;
        return r;
    endfunction

    function automatic conv_req_t date_req(input logic [11:0] y, input logic [3:0] mo,
                                           input logic [4:0] d, input logic [4:0] h,
                                           input logic [5:0] mi, input logic [5:0] s);
        conv_req_t r;
        r        = '0;
        r.op     = escc_pkg::OP_TO_COUNTER;
        r.year   = y;
        r.month  = mo;
        r.day    = d;
        r.hour   = h;
        r.minute = mi;
        r.second = s;
        return r;
    endfunction

    function automatic conv_res_t count_res(input logic [31:0] s);
        conv_res_t r;
        r      = '0;
        r.secs = s;
        return r;
    endfunction

    // random request: all fields noisy, then the used ones shaped
    function automatic conv_req_t random_req();
        conv_req_t   r;
        int unsigned pick;
        r      = {$urandom, $urandom, 7'($urandom)};
        pick   = $urandom_range(0, 99);
        r.op   = ($urandom_range(0, 1) == 0) ? escc_pkg::OP_TO_CALENDAR
                                             : escc_pkg::OP_TO_COUNTER;
        if (r.op == escc_pkg::OP_TO_CALENDAR)
        begin
            // around midnight of a random day, or near the top of the counter
            if (pick >= 50 && pick < 80)
                r.secs = 32'($urandom_range(0, 49710) * 86400) + $urandom_range(0, 2) - 1;
            else if (pick >= 80)
                r.secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        end
        else if (pick < 80)
        begin
            r.year   = 12'($urandom_range(1970, 2106));
            r.month  = 4'($urandom_range(1, 12));
            r.day    = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                                      : $urandom_range(1, 28));
            r.hour   = 5'($urandom_range(0, 23));
            r.minute = 6'($urandom_range(0, 59));
            r.second = 6'($urandom_range(0, 59));
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, fname, want, got);
            error_count++;
        end
    endtask

    // drive one beat and hold it until accepted
    task automatic send_beat(input conv_req_t r, input conv_res_t want, input bit calm);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        opcode        <= r.op;
        seconds_count <= r.secs;
        year_in       <= r.year;
        month_in      <= r.month;
        day_in        <= r.day;
        hour_in       <= r.hour;
        minute_in     <= r.minute;
        second_in     <= r.second;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_dates.push_back(want);
    endtask

    // result side backpressure, with calm windows
    always @(negedge clk)
    begin
        cycle_count++;
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ((cycle_count % 512) < 448 && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, seconds_out %0d",
                         $time, seconds_out);
                error_count++;
            end
            else
            begin
                head = expected_dates.pop_front();
                check_field("seconds_out", head.secs, seconds_out);
                check_field("year_out", 32'(head.year), 32'(year_out));
                check_field("month_out", 32'(head.month), 32'(month_out));
                check_field("day_out", 32'(head.day), 32'(day_out));
                check_field("hour_out", 32'(head.hour), 32'(hour_out));
                check_field("minute_out", 32'(head.minute), 32'(minute_out));
                check_field("second_out", 32'(head.second), 32'(second_out));
                check_field("weekday_out", 32'(head.wday), 32'(weekday_out));
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_epoch_seconds_calendar_converter failed");
            $finish;
        end
    end

    initial
    begin
        conv_req_t r;
        conv_res_t want;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = escc_pkg::OP_TO_CALENDAR;
        seconds_count = '0;
        year_in       = '0;
        month_in      = '0;
        day_in        = '0;
        hour_in       = '0;
        minute_in     = '0;
        second_in     = '0;
        out_ready     = 1'b0;
        error_count   = 0;
        idle_cycles   = 0;
        cycle_count   = 0;
        stall_left    = 0;

        // epoch start and counter top, both directions
        date_table.push_back('{count_req(32'd0), 1'b1,
                               '{32'd0, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd3}});
        date_table.push_back('{count_req(32'hFFFF_FFFF), 1'b1,
                               '{32'd0, 12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 3'd6}});
        date_table.push_back('{date_req(12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0), 1'b1,
                               count_res(32'd0)});
        date_table.push_back('{date_req(12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15), 1'b1,
                               count_res(32'hFFFF_FFFF)});
        // one second past the top wraps to zero, one before the epoch to all ones
        date_table.push_back('{date_req(12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd16), 1'b1,
                               count_res(32'd0)});
        date_table.push_back('{date_req(12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59), 1'b1,
                               count_res(32'hFFFF_FFFF)});
        // leap day, day edges, mid-range counters
        date_table.push_back('{count_req(32'd951782400), 1'b0, '0});
        date_table.push_back('{count_req(32'd951868799), 1'b0, '0});
        date_table.push_back('{count_req(32'd951868800), 1'b0, '0});
        date_table.push_back('{count_req(32'd86399), 1'b0, '0});
        date_table.push_back('{count_req(32'h7FFF_FFFF), 1'b0, '0});
        date_table.push_back('{count_req(32'h8000_0000), 1'b0, '0});
        date_table.push_back('{date_req(12'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0), 1'b0, '0});
        date_table.push_back('{date_req(12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd1), 1'b0, '0});
        // month outside 1..12 and other out-of-range fields
        date_table.push_back('{date_req(12'd2000, 4'd0, 5'd15, 5'd1, 6'd2, 6'd3), 1'b0, '0});
        date_table.push_back('{date_req(12'd2000, 4'd13, 5'd15, 5'd1, 6'd2, 6'd3), 1'b0, '0});
        date_table.push_back('{date_req(12'd2050, 4'd14, 5'd1, 5'd0, 6'd0, 6'd0), 1'b0, '0});
        date_table.push_back('{date_req(12'd0, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63), 1'b0, '0});
        date_table.push_back('{date_req(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63),
                               1'b0, '0});
        date_table.push_back('{date_req(12'd1900, 4'd2, 5'd0, 5'd24, 6'd60, 6'd60), 1'b0, '0});

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (date_table[i])
        begin
            want = date_table[i].fixed ? date_table[i].res : convert_date(date_table[i].req);
            send_beat(date_table[i].req, want, 1'b0);
        end

        // random beats, with back-to-back stretches
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = random_req();
            send_beat(r, convert_date(r), (n % 100) >= 80);
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then give the pipeline time to show any stray beat
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (2 * escc_pkg::NUM_STAGES) @(posedge clk);

        if (error_count == 0)
            $display("tb_epoch_seconds_calendar_converter passed");
        else
            $display("tb_epoch_seconds_calendar_converter failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/escc_pkg.sv
rtl/epoch_seconds_calendar_converter.sv
test/tb_epoch_seconds_calendar_converter.sv
